[rtl/uart_line_command_queue_defines.svh]
// Assertion macros shared by the RTL of the line command queue.
`ifndef UART_LINE_COMMAND_QUEUE_DEFINES_SVH
`define UART_LINE_COMMAND_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ULCQ_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("Implication check failed.");
`define ULCQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("Next-cycle check failed.");
`else
`define ULCQ_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define ULCQ_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

[rtl/ulcq_pkg.sv]
package ulcq_pkg;

   localparam int LINE_SLOTS_DEF = 64;
   localparam int LINE_LEN_DEF   = 32;

   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_CR = 8'd13;

   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_POP     = 1'b1;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_CLOSED   = 3'd1,
      ST_OVERFLOW = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_DATA     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_START,
      S_POP_DATA,
      S_POP_NL
   } state_type;

endpackage

[rtl/uart_line_command_queue.sv]
// Receive items and pops of an empty queue: one result, registered in the next cycle.
// Pop of a line: length read in S_POP_START, first byte in S_POP_DATA, then one byte per cycle
// from the line store while responses drain, LF last; the next transaction waits for the LF.
// Receive transactions are taken one per cycle while results are drained.
// Reset clears the slot pointers, column, line count and control state; line memories are
// not cleared, since each closed slot records its length and later bytes are never read.
module uart_line_command_queue #(
   parameter int LINE_SLOTS = ulcq_pkg::LINE_SLOTS_DEF,
   parameter int LINE_LEN   = ulcq_pkg::LINE_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_status,
   output logic       rsp_last
);

   import ulcq_pkg::*;

`include "uart_line_command_queue_defines.svh"

   localparam int SW = $clog2(LINE_SLOTS);
   localparam int CW = $clog2(LINE_LEN);
   localparam int LW = $clog2(LINE_LEN + 1);
   localparam int NW = $clog2(LINE_SLOTS + 1);
   localparam int DATA_DEPTH = LINE_SLOTS * (2 ** CW);

   state_type   state_ff, state_in;
   logic [LW-1:0] column_ff, column_in;
   logic [SW-1:0] write_slot_ff, write_slot_in;
   logic [SW-1:0] read_slot_ff, read_slot_in;
   logic [NW-1:0] line_count_ff, line_count_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] len_ff, len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_out_byte_ff, rsp_out_byte_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;

   logic             data_wr_en;
   logic [SW+CW-1:0] data_wr_addr;
   logic             data_rd_en;
   logic [SW+CW-1:0] data_rd_addr;
   logic [7:0]       data_q;
   logic             len_wr_en;
   logic             len_rd_en;
   logic [LW-1:0]    len_q;

   logic out_free;
   logic req_fire;
   logic is_term;
   logic [SW-1:0] write_slot_next;
   logic [SW-1:0] read_slot_next;

   ulcq_ram #(
      .DEPTH (DATA_DEPTH),
      .WIDTH (8)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (data_wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (data_q)
   );

   ulcq_ram #(
      .DEPTH (LINE_SLOTS),
      .WIDTH (LW)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (write_slot_ff),
      .wr_data (column_ff),
      .rd_en   (len_rd_en),
      .rd_addr (read_slot_ff),
      .rd_data (len_q)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign is_term   = (req_rx_byte == CH_LF) || (req_rx_byte == CH_CR);

   assign write_slot_next = (write_slot_ff == SW'(LINE_SLOTS - 1)) ? '0 : write_slot_ff + 1'b1;
   assign read_slot_next  = (read_slot_ff == SW'(LINE_SLOTS - 1)) ? '0 : read_slot_ff + 1'b1;

   assign data_wr_addr = {write_slot_ff, column_ff[CW-1:0]};

   always_comb begin
      state_in        = state_ff;
      column_in       = column_ff;
      write_slot_in   = write_slot_ff;
      read_slot_in    = read_slot_ff;
      line_count_in   = line_count_ff;
      idx_in          = idx_ff;
      len_in          = len_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_out_byte_in = rsp_out_byte_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;
      data_wr_en      = 1'b0;
      data_rd_en      = 1'b0;
      data_rd_addr    = {read_slot_ff, idx_ff[CW-1:0]};
      len_wr_en       = 1'b0;
      len_rd_en       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OP_RECEIVE) begin
                  rsp_valid_in    = 1'b1;
                  rsp_out_byte_in = 8'd0;
                  rsp_last_in     = 1'b1;
                  priority if (line_count_ff == NW'(LINE_SLOTS)) begin
                     rsp_status_in = ST_FULL;
                  end else if (is_term) begin
                     len_wr_en     = 1'b1;
                     column_in     = '0;
                     write_slot_in = write_slot_next;
                     line_count_in = line_count_ff + 1'b1;
                     rsp_status_in = ST_CLOSED;
                  end else if (column_ff < LW'(LINE_LEN)) begin
                     data_wr_en    = 1'b1;
                     column_in     = column_ff + 1'b1;
                     rsp_status_in = ST_STORED;
                  end else begin
                     rsp_status_in = ST_OVERFLOW;
                  end
               end else if (line_count_ff == '0) begin
                  rsp_valid_in    = 1'b1;
                  rsp_out_byte_in = 8'd0;
                  rsp_status_in   = ST_EMPTY;
                  rsp_last_in     = 1'b1;
               end else begin
                  len_rd_en = 1'b1;
                  state_in  = S_POP_START;
               end
            end
         end
         S_POP_START: begin
            len_in = len_q;
            if (len_q == '0) begin
               state_in = S_POP_NL;
            end else begin
               data_rd_en   = 1'b1;
               data_rd_addr = {read_slot_ff, {CW{1'b0}}};
               idx_in       = LW'(1);
               state_in     = S_POP_DATA;
            end
         end
         S_POP_DATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DATA;
               if (data_q == 8'd0) begin
                  rsp_out_byte_in = CH_LF;
                  rsp_last_in     = 1'b1;
                  read_slot_in    = read_slot_next;
                  line_count_in   = line_count_ff - 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  rsp_out_byte_in = data_q;
                  rsp_last_in     = 1'b0;
                  if (idx_ff < len_ff) begin
                     data_rd_en = 1'b1;
                     idx_in     = idx_ff + 1'b1;
                  end else begin
                     state_in = S_POP_NL;
                  end
               end
            end
         end
         S_POP_NL: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_DATA;
               rsp_out_byte_in = CH_LF;
               rsp_last_in     = 1'b1;
               read_slot_in    = read_slot_next;
               line_count_in   = line_count_ff - 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         column_ff     <= '0;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         line_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         column_ff     <= column_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         line_count_ff <= line_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      len_ff          <= len_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

   `ULCQ_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, line_count_ff <= NW'(LINE_SLOTS))
   `ULCQ_ASSERT_IMPLIES(a_column_bound, clock, reset, 1'b1, column_ff <= LW'(LINE_LEN))
   `ULCQ_ASSERT_IMPLIES(a_pop_has_line, clock, reset, state_ff != S_IDLE, line_count_ff != '0)
   `ULCQ_ASSERT_NEXT(a_receive_result, clock, reset, req_fire && (req_opcode == OP_RECEIVE), rsp_valid_ff && rsp_last_ff && (rsp_out_byte_ff == 8'd0))
   `ULCQ_ASSERT_NEXT(a_empty_pop, clock, reset, req_fire && (req_opcode == OP_POP) && (line_count_ff == '0), rsp_valid_ff && rsp_last_ff && (rsp_status_ff == ST_EMPTY))

endmodule

[rtl/ulcq_ram.sv]
module ulcq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
